@@ rtl/isl_pkg.sv @@
// Package for the indexed sequence list: request and status codes,
// chain shift operations, sequencer states and the payload structs.
// No dependencies.
package isl_pkg;

    // Default sizing
    localparam int ISL_CAPACITY   = 64;
    localparam int ISL_ITEM_WIDTH = 32;
    // Taps per first-level group of the read-out OR tree
    localparam int ISL_GROUP      = 32;

    // Request codes
    typedef enum logic [3:0] {
        REQ_READ       = 4'd0,
        REQ_WRITE      = 4'd1,
        REQ_INSERT     = 4'd2,
        REQ_REMOVE     = 4'd3,
        REQ_PUSH_FRONT = 4'd4,
        REQ_POP_FRONT  = 4'd5,
        REQ_PUSH_BACK  = 4'd6,
        REQ_POP_BACK   = 4'd7,
        REQ_READ_BACK  = 4'd8,
        REQ_CLEAR      = 4'd9
    } t_req;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CH_HOLD   = 2'd0,
        CH_WRITE  = 2'd1,
        CH_INSERT = 2'd2,
        CH_REMOVE = 2'd3
    } t_chain_op;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_REDUCE = 2'd2,
        S_OUT    = 2'd3
    } t_state;

    // Input item
    typedef struct packed {
        logic [3:0]         req_type;
        logic [6:0]         position;
        logic signed [31:0] data_in;
    } t_in;

    // Result item
    typedef struct packed {
        logic signed [31:0] read_data;
        logic [6:0]         item_count;
        logic               is_empty;
        logic [1:0]         status;
    } t_out;

endpackage

@@ rtl/indexed_sequence_list.sv @@
// Top level of the indexed sequence list: request sequencer, item count,
// the chain of entry cells and a two-level registered read-out OR tree.
// Depends on isl_pkg and isl_cell.
//
//  channel | signals                   | payload | direction
//  --------+---------------------------+---------+----------
//  request | i_valid, o_ready, i_data  | t_in    | in
//  result  | o_valid, i_ready, o_data  | t_out   | out
//
// With no stall, each request passes through the transfer in, execute
// (status, count, the chain operation on the cells and the first OR-tree
// level), the second OR-tree level into the result register, and the
// result state. The next request is taken in the cycle after the result
// transfers.
// Reset clears the sequencer and the count; entries are undefined until
// written. A stalled result holds in its register and blocks new requests.
module indexed_sequence_list
    import isl_pkg::*;
#(
    parameter int CAPACITY   = ISL_CAPACITY,
    parameter int ITEM_WIDTH = ISL_ITEM_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int W     = ITEM_WIDTH;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
    localparam int N_GRP = (CAPACITY + ISL_GROUP - 1) / ISL_GROUP;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    t_state           r_state;
    t_state           n_state;
    t_in              r_req;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_status          r_status;
    t_status          n_status;
    logic [W-1:0]     r_grp [N_GRP];
    logic [W-1:0]     n_grp [N_GRP];
    t_out             r_out;

    logic             w_exec;
    t_chain_op        w_op;
    t_chain_op        w_op_dec;
    logic [IDX_W-1:0] w_pos;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_idx;
    logic [CMP_W-1:0] w_pos_x;
    logic [CMP_W-1:0] w_cnt_x;
    logic [CNT_W-1:0] w_cnt_dec;
    logic             w_in_range;
    logic             w_ins_ok;
    logic             w_full;
    logic             w_empty;
    logic [W-1:0]     w_store;
    logic [W-1:0]     w_or;
    logic [31:0]      w_rd32;
    logic [6:0]       w_cnt7;
    logic [W-1:0]     w_cell [CAPACITY];
    logic [W-1:0]     w_tap  [CAPACITY];

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_EXEC;
            S_EXEC:   n_state = S_REDUCE;
            S_REDUCE: n_state = S_OUT;
            S_OUT:    if (i_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_valid = (r_state == S_OUT);
        w_exec  = (r_state == S_EXEC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request on transfer
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_req <= i_data;
        end
    end

    // Range and capacity checks
    assign w_pos_x    = CMP_W'(r_req.position);
    assign w_cnt_x    = CMP_W'(r_count);
    assign w_cnt_dec  = r_count - CNT_W'(1);
    assign w_in_range = (w_pos_x < w_cnt_x);
    assign w_ins_ok   = (w_pos_x <= w_cnt_x);
    assign w_full     = (r_count >= CAP_CNT);
    assign w_empty    = (r_count == '0);

    // Decode the request into status, count, chain operation and read select
    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        w_op_dec = CH_HOLD;
        w_pos    = w_pos_x[IDX_W-1:0];
        w_rd_en  = 1'b0;
        w_rd_idx = w_pos_x[IDX_W-1:0];
        unique case (r_req.req_type)
            REQ_READ: begin
                if (!w_in_range) n_status = ST_RANGE;
                else w_rd_en = 1'b1;
            end
            REQ_WRITE: begin
                if (!w_in_range) n_status = ST_RANGE;
                else w_op_dec = CH_WRITE;
            end
            REQ_INSERT: begin
                if (!w_ins_ok) n_status = ST_RANGE;
                else if (w_full) n_status = ST_FULL;
                else begin
                    w_op_dec = CH_INSERT;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            REQ_REMOVE: begin
                if (!w_in_range) n_status = ST_RANGE;
                else begin
                    w_op_dec = CH_REMOVE;
                    n_count  = w_cnt_dec;
                end
            end
            REQ_PUSH_FRONT: begin
                w_pos = '0;
                if (w_full) n_status = ST_FULL;
                else begin
                    w_op_dec = CH_INSERT;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            REQ_POP_FRONT: begin
                w_pos = '0;
                if (w_empty) n_status = ST_EMPTY;
                else begin
                    w_op_dec = CH_REMOVE;
                    n_count  = w_cnt_dec;
                end
            end
            REQ_PUSH_BACK: begin
                w_pos = w_cnt_x[IDX_W-1:0];
                if (w_full) n_status = ST_FULL;
                else begin
                    w_op_dec = CH_WRITE;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            REQ_POP_BACK: begin
                if (w_empty) n_status = ST_EMPTY;
                else n_count = w_cnt_dec;
            end
            REQ_READ_BACK: begin
                w_rd_idx = w_cnt_dec[IDX_W-1:0];
                if (w_empty) n_status = ST_EMPTY;
                else w_rd_en = 1'b1;
            end
            REQ_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Apply the chain operation only in the execute cycle
    assign w_op = w_exec ? w_op_dec : CH_HOLD;

    // Store form: sign-extend or truncate the 32-bit item to the entry width
    generate
        if (W > 32) begin : g_store_ext
            assign w_store = {{(W-32){r_req.data_in[31]}}, r_req.data_in};
        end else begin : g_store_trunc
            assign w_store = r_req.data_in[W-1:0];
        end
    endgenerate

    // Chain of cells; the ends see zero neighbors
    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            logic [W-1:0] w_left;
            logic [W-1:0] w_right;
            if (i == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_cell[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_cell[i+1];
            end
            isl_cell #(
                .W     (W),
                .IDX_W (IDX_W),
                .INDEX (i)
            ) u_cell (
                .i_clk    (i_clk),
                .i_op     (w_op),
                .i_pos    (w_pos),
                .i_data   (w_store),
                .i_left   (w_left),
                .i_right  (w_right),
                .i_rd_en  (w_rd_en & w_exec),
                .i_rd_idx (w_rd_idx),
                .o_data   (w_cell[i]),
                .o_tap    (w_tap[i])
            );
        end
    endgenerate

    // First tree level: OR the taps of each group
    always_comb begin
        for (int g = 0; g < N_GRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < ISL_GROUP; k++) begin
                if (g * ISL_GROUP + k < CAPACITY) begin
                    n_grp[g] = n_grp[g] | w_tap[g * ISL_GROUP + k];
                end
            end
        end
    end

    // Hold count and status; register the group results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_status <= n_status;
            r_grp    <= n_grp;
        end
    end

    // Second tree level
    always_comb begin
        w_or = '0;
        for (int g = 0; g < N_GRP; g++) begin
            w_or = w_or | r_grp[g];
        end
    end

    // Read form: sign-extend the entry to 32 bits or keep its low 32 bits
    generate
        if (W >= 32) begin : g_read_trunc
            assign w_rd32 = w_or[31:0];
        end else begin : g_read_ext
            assign w_rd32 = {{(32-W){w_or[W-1]}}, w_or};
        end
        if (CNT_W >= 7) begin : g_cnt_trunc
            assign w_cnt7 = r_count[6:0];
        end else begin : g_cnt_ext
            assign w_cnt7 = 7'(r_count);
        end
    endgenerate

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_REDUCE) begin
            r_out.read_data  <= w_rd32;
            r_out.item_count <= w_cnt7;
            r_out.is_empty   <= (r_count == '0);
            r_out.status     <= r_status;
        end
    end

    assign o_data = r_out;

endmodule

@@ rtl/isl_cell.sv @@
// One cell of the list chain: holds one entry, loads it from the request,
// from its left or right neighbor, and drives a masked read tap.
// Depends on isl_pkg.
module isl_cell
    import isl_pkg::*;
#(
    parameter int W     = ISL_ITEM_WIDTH,
    parameter int IDX_W = 6,
    parameter int INDEX = 0
) (
    input  logic             i_clk,
    input  t_chain_op        i_op,
    input  logic [IDX_W-1:0] i_pos,
    input  logic [W-1:0]     i_data,
    input  logic [W-1:0]     i_left,
    input  logic [W-1:0]     i_right,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    output logic [W-1:0]     o_data,
    output logic [W-1:0]     o_tap
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [W-1:0] r_entry;
    logic [W-1:0] n_entry;
    logic         w_at;
    logic         w_above;

    assign w_at    = (i_pos == MY_IDX);
    assign w_above = (MY_IDX > i_pos);

    // Select the next entry value
    always_comb begin
        n_entry = r_entry;
        case (i_op)
            CH_WRITE: begin
                if (w_at) n_entry = i_data;
            end
            CH_INSERT: begin
                if (w_at) n_entry = i_data;
                else if (w_above) n_entry = i_left;
            end
            CH_REMOVE: begin
                if (w_at || w_above) n_entry = i_right;
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_data = r_entry;
    assign o_tap  = (i_rd_en && (i_rd_idx == MY_IDX)) ? r_entry : '0;

endmodule
